// ----- rtl/crlp_pkg.sv -----
// Shared types, constants and helpers for the control reply line parser.
// No dependencies.
package crlp_pkg;

  // Width of the internal position and value counters
  localparam int COUNT_BITS = 16;
  // Width of the reported lengths
  localparam int LEN_BITS   = 16;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [LEN_BITS-1:0]   len_t;

  // Characters the parser looks for
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Position of the line type character
  localparam count_t TYPE_POS = count_t'(3);
  localparam count_t BODY_POS = count_t'(4);

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_FINAL = 2'd1,
    MODE_VALUE = 2'd2
  } scan_mode_t;

  // Saturating increment
  function automatic count_t count_inc(input count_t v);
    count_inc = (v == '1) ? v : v + count_t'(1);
  endfunction

  // Clamp a counter to the reported length width
  function automatic len_t report_len(input count_t v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'((1 << LEN_BITS) - 1)) begin
      report_len = '1;
    end else begin
      report_len = w[LEN_BITS-1:0];
    end
  endfunction

endpackage

// ----- rtl/control_reply_line_parser_top.sv -----
// Top level of the control reply line parser: per-byte line scanner with a
// registered result beat. Depends on crlp_pkg.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | data_byte
//  out     | out_valid/out_stall | store_*, line_*, key_*, value_*, reply_*,
//          |                     | status_code
//
// One byte per cycle while out is not stalled: each byte passes through the
// mode logic and its result is registered in the output register.
// A byte is taken whenever the output register is empty or being emptied.
// Reset (rst, synchronous) returns the scanner to the line start and empties
// the output register. A stall on out holds the result and stalls in.
module control_reply_line_parser_top
  import crlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        store_valid,
  output logic [7:0]  store_byte,
  output logic        line_done,
  output logic [15:0] line_length,
  output logic        key_done,
  output logic [15:0] key_length,
  output logic        value_done,
  output logic [15:0] value_length,
  output logic        value_is_pair,
  output logic        reply_done,
  output logic        reply_ok,
  output logic [23:0] status_code
);

  scan_mode_t  scan_mode, scan_mode_next;
  count_t      line_position, line_position_next;
  count_t      value_count, value_count_next;
  logic        first_equals_pending, first_equals_pending_next;
  logic        pair_seen, pair_seen_next;
  logic [23:0] recent_stored_bytes, recent_stored_bytes_next;
  logic [23:0] latched_code, latched_code_next;
  logic        latched_ok, latched_ok_next;

  // Result of the current byte
  logic        r_store_valid;
  logic [7:0]  r_store_byte;
  logic        r_line_done;
  len_t        r_line_length;
  logic        r_key_done;
  len_t        r_key_length;
  logic        r_value_done;
  len_t        r_value_length;
  logic        r_value_is_pair;
  logic        r_reply_done;
  logic        r_reply_ok;
  logic [23:0] r_status_code;

  logic   accept;
  logic   is_cr, is_lf;
  count_t lp_inc;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_cr    = (data_byte == CH_CR);
  assign is_lf    = (data_byte == CH_LF);

  // Mode logic: next state and result for one byte
  always_comb begin
    scan_mode_next            = scan_mode;
    line_position_next        = line_position;
    value_count_next          = value_count;
    first_equals_pending_next = first_equals_pending;
    pair_seen_next            = pair_seen;
    latched_code_next         = latched_code;
    latched_ok_next           = latched_ok;
    lp_inc                    = count_inc(line_position);

    r_store_valid   = 1'b0;
    r_store_byte    = '0;
    r_line_done     = 1'b0;
    r_line_length   = '0;
    r_key_done      = 1'b0;
    r_key_length    = '0;
    r_value_done    = 1'b0;
    r_value_length  = '0;
    r_value_is_pair = 1'b0;
    r_reply_done    = 1'b0;
    r_reply_ok      = 1'b0;
    r_status_code   = '0;

    case (scan_mode)
      MODE_FINAL: begin
        if (!is_cr && !is_lf) begin
          r_store_valid      = 1'b1;
          r_store_byte       = data_byte;
          line_position_next = lp_inc;
        end
        if (is_lf) begin
          r_line_done        = 1'b1;
          r_line_length      = report_len(line_position);
          line_position_next = '0;
          r_reply_done       = 1'b1;
          r_reply_ok         = latched_ok;
          r_status_code      = latched_code;
          scan_mode_next     = MODE_START;
        end
      end
      MODE_VALUE: begin
        if (data_byte == CH_EQ && first_equals_pending) begin
          r_key_done                = 1'b1;
          r_key_length              = report_len(value_count);
          first_equals_pending_next = 1'b0;
          pair_seen_next            = 1'b1;
        end
        if (!is_cr && !is_lf) begin
          r_store_valid      = 1'b1;
          r_store_byte       = data_byte;
          line_position_next = lp_inc;
          value_count_next   = r_key_done ? '0 : count_inc(value_count);
        end
        // line end: length counts the line feed too, and the feed is stored
        if (is_lf) begin
          r_line_done        = 1'b1;
          r_line_length      = report_len(lp_inc);
          line_position_next = '0;
          r_value_done       = 1'b1;
          r_value_length     = report_len(value_count);
          r_value_is_pair    = pair_seen;
          r_store_valid      = 1'b1;
          r_store_byte       = CH_LF;
          scan_mode_next     = MODE_START;
        end
      end
      default: begin
        if (!is_cr) begin
          r_store_valid = 1'b1;
          r_store_byte  = data_byte;
        end
        if (line_position == TYPE_POS) begin
          line_position_next = BODY_POS;
          if (data_byte == CH_SPACE) begin
            latched_code_next = recent_stored_bytes;
            latched_ok_next   = (recent_stored_bytes[23:16] == CH_TWO ||
                                 recent_stored_bytes[23:16] == CH_SIX) &&
                                recent_stored_bytes[15:8] == CH_FIVE &&
                                recent_stored_bytes[7:0] == CH_ZERO;
            scan_mode_next    = MODE_FINAL;
          end else begin
            value_count_next          = '0;
            first_equals_pending_next = 1'b1;
            pair_seen_next            = 1'b0;
            scan_mode_next            = MODE_VALUE;
          end
        end else if (is_lf) begin
          r_line_done        = 1'b1;
          r_line_length      = report_len(line_position);
          line_position_next = '0;
        end else if (!is_cr) begin
          line_position_next = lp_inc;
        end
      end
    endcase

    recent_stored_bytes_next = r_store_valid ?
        {recent_stored_bytes[15:0], r_store_byte} : recent_stored_bytes;
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode            <= MODE_START;
      line_position        <= '0;
      value_count          <= '0;
      first_equals_pending <= 1'b0;
      pair_seen            <= 1'b0;
      recent_stored_bytes  <= '0;
      latched_code         <= '0;
      latched_ok           <= 1'b0;
    end else if (accept) begin
      scan_mode            <= scan_mode_next;
      line_position        <= line_position_next;
      value_count          <= value_count_next;
      first_equals_pending <= first_equals_pending_next;
      pair_seen            <= pair_seen_next;
      recent_stored_bytes  <= recent_stored_bytes_next;
      latched_code         <= latched_code_next;
      latched_ok           <= latched_ok_next;
    end
  end

  // Output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      store_valid   <= r_store_valid;
      store_byte    <= r_store_byte;
      line_done     <= r_line_done;
      line_length   <= r_line_length;
      key_done      <= r_key_done;
      key_length    <= r_key_length;
      value_done    <= r_value_done;
      value_length  <= r_value_length;
      value_is_pair <= r_value_is_pair;
      reply_done    <= r_reply_done;
      reply_ok      <= r_reply_ok;
      status_code   <= r_status_code;
    end
  end

  // A finished reply or value line always closes a line
  a_end_closes_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && (reply_done || value_done) |-> line_done)
    else $error("reply or value end without line end");

  // A value line end stores its line feed
  a_value_stores_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_done |-> store_valid && store_byte == CH_LF)
    else $error("value end without stored line feed");

  // The key split never coincides with a line end
  a_key_not_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_done |-> !line_done)
    else $error("key split on a line end");

  // Accepting a byte always leaves a beat in the output register
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted byte lost");

  // A stalled output beat blocks further input
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !accept)
    else $error("input taken over a stalled beat");

endmodule
